FILE: sv/m1u_pkg.sv
// Shared types and constants for the MIDI 1.0 byte to UMP word converter.
`timescale 1ns / 1ps

package m1u_pkg;

  typedef enum logic [1:0] {
    RC_OK    = 2'd0,
    RC_MORE  = 2'd1,
    RC_SKIP  = 2'd2,
    RC_ERROR = 2'd3
  } result_code_e;

  localparam logic [3:0] MT_REALTIME  = 4'h1;
  localparam logic [3:0] MT_CHAN_VOICE = 4'h2;

  localparam logic [7:0] BYTE_REALTIME_MIN = 8'hF8;
  localparam logic [7:0] BYTE_SYSTEM_MIN   = 8'hF0;
  localparam logic [7:0] BYTE_ACTIVE_SENSE = 8'hFE;

  localparam int unsigned MidiByteW = 8;
  localparam int unsigned UmpWordW  = 32;
  localparam int unsigned GroupW    = 4;

endpackage

FILE: sv/midi1_bytes_to_ump_words.sv
// Top level: converts a MIDI 1.0 byte stream into UMP words, one result per byte.
`timescale 1ns / 1ps

// The input stream carries one MIDI 1.0 byte per transaction on s_axis_tdata.
// Every input transaction produces exactly one output transaction: a 32-bit
// UMP word on m_axis_tdata and a result code on m_axis_tuser (ok, need more,
// skipped, error). The word is zero unless the code is ok.
// A byte is captured in an input register, decoded by short combinational
// logic against the parser state, and written to an output register, from
// which the result is offered on m_axis_tdata and m_axis_tuser.
// Throughput is one byte per cycle while the receiver does not stall; the parser
// state is updated in the same cycle the byte moves to the output register, so consecutive bytes chain.
// When the receiver stalls, the output register holds its result and the
// input register holds one more byte; after that s_axis_tready falls.
// Reset clears both valid flags, the parser phase, running status and the
// group register. cfg_we_i writes the UMP group for channel voice words; it
// must only be written while no byte is in flight.
module midi1_bytes_to_ump_words (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [m1u_pkg::GroupW-1:0]            cfg_wdata_i,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [m1u_pkg::MidiByteW-1:0]         s_axis_tdata,   // midi_byte
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [m1u_pkg::UmpWordW-1:0]          m_axis_tdata,   // ump_word
  output logic [1:0]                            m_axis_tuser    // result_code
);

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_STATUS = 2'd1,
    PH_DATA1  = 2'd2
  } phase_e;

  logic                          in_vld_q;
  logic [m1u_pkg::MidiByteW-1:0] in_byte_q;
  logic                          out_vld_q;
  logic [m1u_pkg::UmpWordW-1:0]  out_word_q;
  m1u_pkg::result_code_e         out_code_q;
  logic [m1u_pkg::GroupW-1:0]    group_q;

  phase_e      phase_q, phase_d;
  logic [7:0]  rs_q, rs_d;
  logic        held_q, held_d;
  logic [6:0]  first_q, first_d;

  logic                          move;
  logic [m1u_pkg::UmpWordW-1:0]  word_d;
  m1u_pkg::result_code_e         code_d;

  assign move          = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || move;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_word_q;
  assign m_axis_tuser  = out_code_q;

  always_comb begin
    phase_e     ph;
    logic       held;
    logic [3:0] nib;
    logic [1:0] need;
    ph      = phase_q;
    held    = held_q;
    nib     = rs_q[7:4];
    need    = 2'd0;
    phase_d = phase_q;
    rs_d    = rs_q;
    held_d  = held_q;
    first_d = first_q;
    word_d  = '0;
    code_d  = m1u_pkg::RC_SKIP;
    if (nib inside {4'h8, 4'h9, 4'hA, 4'hB, 4'hE}) begin
      need = 2'd2;
    end else if (nib inside {4'hC, 4'hD}) begin
      need = 2'd1;
    end
    if (in_byte_q >= m1u_pkg::BYTE_REALTIME_MIN) begin
      if (in_byte_q != m1u_pkg::BYTE_ACTIVE_SENSE) begin
        word_d = {m1u_pkg::MT_REALTIME, 4'h0, in_byte_q, 16'h0000};
        code_d = m1u_pkg::RC_OK;
      end
    end else if (in_byte_q >= m1u_pkg::BYTE_SYSTEM_MIN) begin
      rs_d    = 8'h00;
      phase_d = PH_IDLE;
    end else if (in_byte_q[7]) begin
      rs_d    = in_byte_q;
      held_d  = 1'b0;
      phase_d = PH_STATUS;
      code_d  = m1u_pkg::RC_MORE;
    end else begin
      if (ph == PH_IDLE && rs_q != 8'h00) begin
        ph   = PH_STATUS;
        held = 1'b0;
      end
      held_d = held;
      if (ph != PH_STATUS && ph != PH_DATA1) begin
        phase_d = PH_IDLE;
        code_d  = m1u_pkg::RC_ERROR;
      end else if (need == 2'd0) begin
        phase_d = PH_IDLE;
        code_d  = m1u_pkg::RC_ERROR;
      end else if (!held && need == 2'd2) begin
        first_d = in_byte_q[6:0];
        held_d  = 1'b1;
        phase_d = PH_DATA1;
        code_d  = m1u_pkg::RC_MORE;
      end else begin
        word_d[31:16] = {m1u_pkg::MT_CHAN_VOICE, group_q, nib, rs_q[3:0]};
        if (need == 2'd2) begin
          word_d[15:0] = {1'b0, first_q, in_byte_q};
        end else begin
          word_d[15:0] = {in_byte_q, 8'h00};
        end
        phase_d = PH_IDLE;
        held_d  = 1'b0;
        code_d  = m1u_pkg::RC_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      in_byte_q  <= '0;
      out_vld_q  <= 1'b0;
      out_word_q <= '0;
      out_code_q <= m1u_pkg::RC_OK;
      group_q    <= '0;
      phase_q    <= PH_IDLE;
      rs_q       <= 8'h00;
      held_q     <= 1'b0;
      first_q    <= 7'h00;
    end else begin
      if (cfg_we_i) begin
        group_q <= cfg_wdata_i;
      end
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
        if (s_axis_tvalid) begin
          in_byte_q <= s_axis_tdata;
        end
      end
      if (move) begin
        out_vld_q  <= 1'b1;
        out_word_q <= word_d;
        out_code_q <= code_d;
        phase_q    <= phase_d;
        rs_q       <= rs_d;
        held_q     <= held_d;
        first_q    <= first_d;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  a_data1_holds_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA1 |-> held_q)
    else $error("data1 phase without a held data byte");

  a_phase_has_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_IDLE |-> rs_q != 8'h00)
    else $error("parser active without running status");

  a_status_is_voice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rs_q != 8'h00 |-> rs_q[7] && rs_q[7:4] != 4'hF)
    else $error("running status is not a channel voice status");

  a_word_zero_unless_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_code_q != m1u_pkg::RC_OK |-> out_word_q == '0)
    else $error("nonzero word with a non-ok result code");

endmodule

FILE: dv/midi1_bytes_to_ump_words_tb.sv
// Self-checking testbench for the MIDI 1.0 byte to UMP word converter.
`timescale 1ns / 1ps

module midi1_bytes_to_ump_words_tb;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_STATUS = 2'd1,
    PH_DATA1  = 2'd2
  } parse_phase_e;

  typedef struct packed {
    logic [m1u_pkg::UmpWordW-1:0] word;
    m1u_pkg::result_code_e        code;
  } ump_result_t;

  localparam int BYTES_PER_SETTING = 256;
  localparam int GROUP_SETTINGS    = 5;
  localparam int LONG_HOLD_AT      = 600;
  localparam int LONG_HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT       = 200000;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [m1u_pkg::GroupW-1:0]    cfg_wdata_i = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [m1u_pkg::MidiByteW-1:0] s_axis_tdata = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [m1u_pkg::UmpWordW-1:0]  m_axis_tdata;
  logic [1:0]                    m_axis_tuser;

  midi1_bytes_to_ump_words i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Predictor state.
  parse_phase_e                  parse_ph = PH_IDLE;
  logic [7:0]                    run_status = '0;
  logic                          data_held = 1'b0;
  logic [6:0]                    first_data = '0;
  logic [m1u_pkg::GroupW-1:0]    group_reg = '0;

  logic [m1u_pkg::MidiByteW-1:0] midi_bytes_q[$];
  ump_result_t                   ump_results_q[$];
  ump_result_t                   next_expected;

  logic                          byte_taken = 1'b0;
  int                            bytes_in = 0;
  int                            mismatches = 0;
  int                            code_hits[4] = '{0, 0, 0, 0};
  int                            cycle_count = 0;
  int                            burst_left = 8;
  int                            gap_left = 0;
  int                            rx_tick = 0;
  int                            rx_mode = 0;
  int                            hold_left = 0;
  bit                            hold_done = 1'b0;

  logic [7:0] directed_bytes[25] = '{
    8'h00, 8'h7F, 8'hF8, 8'hFF, 8'hFE, 8'h90, 8'h3C, 8'h7F, 8'h3C, 8'h00,
    8'hC5, 8'h7F, 8'hD0, 8'h00, 8'hF7, 8'h40, 8'hEF, 8'h7F, 8'h7F, 8'hB3,
    8'h07, 8'hF8, 8'h64, 8'h80, 8'h00
  };

  function automatic ump_result_t convert_midi_byte(input logic [7:0] b);
    ump_result_t r;
    logic [3:0]  nib;
    int          need;
    r.word = '0;
    r.code = m1u_pkg::RC_SKIP;
    if (b >= m1u_pkg::BYTE_REALTIME_MIN) begin
      if (b != m1u_pkg::BYTE_ACTIVE_SENSE) begin
        r.word = {m1u_pkg::MT_REALTIME, 4'h0, b, 16'h0000};
        r.code = m1u_pkg::RC_OK;
      end
      return r;
    end
    if (b >= m1u_pkg::BYTE_SYSTEM_MIN) begin
      run_status = '0;
      parse_ph = PH_IDLE;
      return r;
    end
    if (b[7]) begin
      run_status = b;
      data_held = 1'b0;
      parse_ph = PH_STATUS;
      r.code = m1u_pkg::RC_MORE;
      return r;
    end
    if (parse_ph == PH_IDLE && run_status != 8'h00) begin
      parse_ph = PH_STATUS;
      data_held = 1'b0;
    end
    r.code = m1u_pkg::RC_ERROR;
    if (parse_ph != PH_STATUS && parse_ph != PH_DATA1) begin
      parse_ph = PH_IDLE;
      return r;
    end
    nib = run_status[7:4];
    case (nib)
      4'h8, 4'h9, 4'hA, 4'hB, 4'hE: need = 2;
      4'hC, 4'hD: need = 1;
      default: need = 0;
    endcase
    if (need == 0) begin
      parse_ph = PH_IDLE;
      return r;
    end
    if (!data_held && need == 2) begin
      first_data = b[6:0];
      data_held = 1'b1;
      parse_ph = PH_DATA1;
      r.code = m1u_pkg::RC_MORE;
      return r;
    end
    r.word = {m1u_pkg::MT_CHAN_VOICE, group_reg, nib, run_status[3:0], 16'h0000};
    if (need == 2) begin
      r.word[15:0] = {1'b0, first_data, b};
    end else begin
      r.word[15:8] = b;
    end
    parse_ph = PH_IDLE;
    data_held = 1'b0;
    r.code = m1u_pkg::RC_OK;
    return r;
  endfunction

  // Sender: bursts of random length separated by random gaps.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || byte_taken) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (midi_bytes_q.size() != 0) begin
        s_axis_tdata <= midi_bytes_q.pop_front();
        s_axis_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: randomly chosen stall modes, plus one long hold-off.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      rx_tick <= rx_tick + 1;
      if (rx_tick % 50 == 0) begin
        rx_mode <= $urandom_range(0, 3);
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && bytes_in >= LONG_HOLD_AT) begin
        hold_done <= 1'b1;
        hold_left <= LONG_HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 1) == 1);
          2: m_axis_tready <= ($urandom_range(0, 4) == 0);
          default: m_axis_tready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // Input transactions feed the predictor; output transactions are checked.
  always @(posedge clk_i) begin
    byte_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      ump_results_q.push_back(convert_midi_byte(s_axis_tdata));
      bytes_in <= bytes_in + 1;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      code_hits[m_axis_tuser] <= code_hits[m_axis_tuser] + 1;
      if (ump_results_q.size() == 0) begin
        $display("%0t: unexpected transaction, word %h code %0d", $time,
                 m_axis_tdata, m_axis_tuser);
        mismatches = mismatches + 1;
      end else begin
        next_expected = ump_results_q.pop_front();
        if (m_axis_tdata !== next_expected.word) begin
          $display("%0t: ump_word expected %h actual %h", $time,
                   next_expected.word, m_axis_tdata);
          mismatches = mismatches + 1;
        end
        if (m_axis_tuser !== next_expected.code) begin
          $display("%0t: result_code expected %0d actual %0d", $time,
                   next_expected.code, m_axis_tuser);
          mismatches = mismatches + 1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
               ump_results_q.size());
      $display("midi1_bytes_to_ump_words test failed");
      $finish;
    end
  end

  initial begin
    logic [7:0]                 gen_status;
    logic [m1u_pkg::GroupW-1:0] new_group;
    bit                         have_status;
    int                         kind;
    int                         n_data;
    gen_status = 8'h90;
    have_status = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (directed_bytes[i]) begin
      midi_bytes_q.push_back(directed_bytes[i]);
    end
    for (int p = 0; p <= GROUP_SETTINGS; p++) begin
      while (midi_bytes_q.size() != 0 || s_axis_tvalid || ump_results_q.size() != 0) begin
        @(negedge clk_i);
      end
      repeat (4) @(negedge clk_i);
      if (p < GROUP_SETTINGS) begin
        case (p)
          0: new_group = 4'hF;
          1: new_group = 4'($urandom_range(1, 14));
          2: new_group = 4'h0;
          3: new_group = 4'($urandom_range(0, 15));
          default: new_group = 4'hF;
        endcase
        cfg_we_i <= 1'b1;
        cfg_wdata_i <= new_group;
        group_reg = new_group;
        @(negedge clk_i);
        cfg_we_i <= 1'b0;
        while (midi_bytes_q.size() < BYTES_PER_SETTING) begin
          kind = $urandom_range(0, 99);
          if (kind < 70) begin
            if (!have_status || $urandom_range(0, 2) != 0) begin
              gen_status[7:4] = 4'($urandom_range(8, 14));
              gen_status[3:0] = 4'($urandom_range(0, 15));
              midi_bytes_q.push_back(gen_status);
              have_status = 1'b1;
            end
            n_data = (gen_status[7:4] == 4'hC || gen_status[7:4] == 4'hD) ? 1 : 2;
            for (int k = 0; k < n_data; k++) begin
              if ($urandom_range(0, 9) == 0) begin
                midi_bytes_q.push_back(8'($urandom_range(8'hF8, 8'hFF)));
              end
              midi_bytes_q.push_back(8'($urandom_range(0, 8'h7F)));
            end
          end else if (kind < 80) begin
            midi_bytes_q.push_back(8'($urandom_range(8'hF8, 8'hFF)));
          end else if (kind < 88) begin
            midi_bytes_q.push_back(8'($urandom_range(8'hF0, 8'hF7)));
            have_status = 1'b0;
          end else begin
            midi_bytes_q.push_back(8'($urandom_range(0, 8'hFF)));
          end
        end
      end
    end
    repeat (8) @(posedge clk_i);
    $display("Converted %0d MIDI bytes under %0d group settings after reset.", bytes_in,
             GROUP_SETTINGS + 1);
    $display("Results seen: ok %0d, need more %0d, skipped %0d, error %0d.",
             code_hits[m1u_pkg::RC_OK], code_hits[m1u_pkg::RC_MORE],
             code_hits[m1u_pkg::RC_SKIP], code_hits[m1u_pkg::RC_ERROR]);
    if (mismatches == 0) begin
      $display("midi1_bytes_to_ump_words test passed");
    end else begin
      $display("midi1_bytes_to_ump_words test failed");
    end
    $finish;
  end

endmodule
